// ===== src/pli_pkg.sv =====
package pli_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_POINT_COUNT = 1'b0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDN,
    ST_CHK,
    ST_SISS,
    ST_SCMP,
    ST_JRD,
    ST_JCAP,
    ST_ICAP,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== src/pli_ifs.sv =====
interface pli_in_if;
  logic                         valid;
  logic                         ready;
  pli_pkg::opcode_t             opcode;
  logic [pli_pkg::IDX_W-1:0]    entry_index;
  logic [pli_pkg::FIELD_W-1:0]  grid_x;
  logic [pli_pkg::FIELD_W-1:0]  grid_y;
  logic [pli_pkg::FIELD_W-1:0]  query_x;

  modport source (output valid, opcode, entry_index, grid_x, grid_y, query_x, input ready);
  modport sink   (input valid, opcode, entry_index, grid_x, grid_y, query_x, output ready);
endinterface

interface pli_out_if;
  logic                         valid;
  logic                         ready;
  logic [pli_pkg::FIELD_W-1:0]  interp_y;
  logic                         out_of_range;
  logic                         exact_hit;

  modport source (output valid, interp_y, out_of_range, exact_hit, input ready);
  modport sink   (input valid, interp_y, out_of_range, exact_hit, output ready);
endinterface

// ===== src/pli_mem.sv =====
module pli_mem #(
  parameter int DEPTH = pli_pkg::TABLE_DEPTH_DEF,
  parameter int VW    = pli_pkg::VALUE_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wx,
  input  logic [VW-1:0] wy,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rx,
  output logic [VW-1:0] ry
);
  // x and y of a breakpoint side by side in one word
  logic [2*VW-1:0] mem [DEPTH];
  logic [2*VW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
    rd_r <= mem[raddr];
  end

  assign rx = rd_r[2*VW-1:VW];
  assign ry = rd_r[VW-1:0];
endmodule

// ===== src/pli_div.sv =====
module pli_div #(
  parameter int NW = 66,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   sh;
  logic          ge;

  // restoring, one quotient bit a cycle; the remainder stays below the divisor
  always_comb begin
    sh      = {rem_r, quo_r[NW-1]};
    ge      = sh >= {1'b0, dv_r};
    rem_nxt = ge ? DW'(sh - {1'b0, dv_r}) : sh[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ===== src/piecewise_linear_table_interpolator.sv =====
// Piecewise linear interpolator over a breakpoint table in signed Q16.16. A load item
// (opcode 0) writes x and y of one breakpoint and gives no result; a query
// item (opcode 1) gives one result: out_of_range when the query lies outside the first
// and last breakpoints in use, the breakpoint's y with exact_hit when it lands on one,
// the upper breakpoint's y with no flag when the bracketing interval is empty, and
// otherwise the interpolated value, truncated toward zero and saturated. Register
// point_count (byte address 0) selects the leading entries in use, clamped to
// 2..TABLE_DEPTH. The table lives in one single-port-read memory with a registered read,
// so a query reads the first and last entries for the range test, one entry per binary
// search step (at most ceil(log2(n+1)) steps) and then the bracketing entries; it then
// multiplies, sums and runs the bit-serial divider. One item is worked at a time;
// a finished result waits in the output register while the next item is taken.
module piecewise_linear_table_interpolator #(
  parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = pli_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pli_in_if.sink                         in_ch,
  pli_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pli_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pli_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pli_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import pli_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);  // holds the count itself
  localparam int XW = VW + 1;                   // x differences
  localparam int PW = 2 * VW + 2;               // products and their sum
  localparam int DW = VW + 1;                   // divisor a + b

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    point_count_r;
  logic [NW-1:0]       n_r;
  logic signed [VW-1:0] q_r, x0_r, xj_r, yj_r, yi_r;
  logic [NW-1:0]       lo_r, hi_r;
  logic [AW-1:0]       mid_r, j_r;
  logic signed [XW-1:0] a_r, b_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic                neg_r;
  logic signed [VW-1:0] res_y_r;
  logic                res_oor_r, res_hit_r;

  logic                out_valid_r;
  logic [FIELD_W-1:0]  out_y_r;
  logic                out_oor_r, out_hit_r;

  // memory side
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic signed [VW-1:0] rd_x, rd_y;

  logic                div_start, div_done;
  logic [PW-1:0]       div_quo;

  // configuration
  logic                cfg_wr;
  logic [31:0]         pc32, n32;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT)
                      ? CFG_DATA_W'(point_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(2);
    end else if (cfg_wr) begin
      point_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // points in use, clamped to 2..TABLE_DEPTH
  always_comb begin
    pc32 = 32'(point_count_r);
    if (pc32 < 32'd2) begin
      n32 = 32'd2;
    end else if (pc32 > 32'(TABLE_DEPTH)) begin
      n32 = 32'(TABLE_DEPTH);
    end else begin
      n32 = pc32;
    end
  end

  // load path: low bits of each field, slots beyond the table dropped
  logic in_acc, ld_acc, qry_acc;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign ld_acc    = in_acc && (in_ch.opcode == OP_LOAD);
  assign qry_acc   = in_acc && (in_ch.opcode == OP_QUERY);
  assign mem_we    = ld_acc && (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
  assign mem_waddr = AW'(32'(in_ch.entry_index));

  pli_mem #(.DEPTH(TABLE_DEPTH), .VW(VW), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wx    (in_ch.grid_x[VW-1:0]),
    .wy    (in_ch.grid_y[VW-1:0]),
    .raddr (mem_raddr),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  // search and interval decisions
  logic [NW-1:0]        mid_c;
  logic                 oor_c, more_c, lt_c, hit_c, bad_c;
  logic signed [XW-1:0] a_c, b_c;
  logic                 out_free;

  always_comb begin
    mid_c  = lo_r + ((hi_r - lo_r) >> 1);
    oor_c  = (q_r < x0_r) || (q_r > rd_x);
    more_c = lo_r < hi_r;
    lt_c   = rd_x < q_r;
    hit_c  = (rd_x == q_r) || (j_r == '0);
    a_c    = XW'(xj_r) - XW'(q_r);
    b_c    = XW'(q_r) - XW'(rd_x);
    bad_c  = (a_c <= 0) || (b_c <= 0);
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (qry_acc) state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RDN;
      ST_RDN:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = oor_c ? ST_OUT : ST_SISS;
      ST_SISS: state_nxt = more_c ? ST_SCMP : ST_JRD;
      ST_SCMP: state_nxt = ST_SISS;
      ST_JRD:  state_nxt = ST_JCAP;
      ST_JCAP: state_nxt = hit_c ? ST_OUT : ST_ICAP;
      ST_ICAP: state_nxt = bad_c ? ST_OUT : ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    mem_raddr   = '0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_RDN:  mem_raddr = AW'(n_r - 1'b1);
      ST_SISS: mem_raddr = AW'(mid_c);
      ST_JRD:  mem_raddr = j_r;
      ST_JCAP: mem_raddr = j_r - 1'b1;
      ST_SUM:  div_start = 1'b1;
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  logic signed [PW-1:0] sum_c;
  logic [PW-1:0]        mag_c;
  logic signed [VW-1:0] sat_c;
  localparam logic [PW-1:0] LIM = PW'(1) << (VW - 1);

  always_comb begin
    sum_c = p1_r + p2_r;
    mag_c = sum_c[PW-1] ? PW'(-sum_c) : PW'(sum_c);
    if (neg_r) begin
      sat_c = (div_quo > LIM) ? {1'b1, {(VW-1){1'b0}}} : VW'(-div_quo);
    end else begin
      sat_c = (div_quo >= LIM) ? {1'b0, {(VW-1){1'b1}}} : VW'(div_quo);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q_r <= $signed(in_ch.query_x[VW-1:0]);
        n_r <= NW'(n32);
      end
      ST_RDN: x0_r <= rd_x;
      ST_CHK: begin
        lo_r      <= '0;
        hi_r      <= n_r;
        res_y_r   <= '0;
        res_oor_r <= 1'b1;
        res_hit_r <= 1'b0;
      end
      ST_SISS: begin
        mid_r <= AW'(mid_c);
        j_r   <= (lo_r >= n_r) ? AW'(n_r - 1'b1) : AW'(lo_r);
      end
      ST_SCMP: begin
        if (lt_c) begin
          lo_r <= NW'(mid_r) + 1'b1;
        end else begin
          hi_r <= NW'(mid_r);
        end
      end
      ST_JCAP: begin
        xj_r      <= rd_x;
        yj_r      <= rd_y;
        res_y_r   <= rd_y;
        res_oor_r <= 1'b0;
        res_hit_r <= 1'b1;
      end
      ST_ICAP: begin
        // bad interval keeps yj with no flag
        yi_r      <= rd_y;
        a_r       <= a_c;
        b_r       <= b_c;
        res_hit_r <= 1'b0;
      end
      ST_MUL: begin
        p1_r <= PW'(a_r) * PW'(yi_r);
        p2_r <= PW'(b_r) * PW'(yj_r);
      end
      ST_SUM: neg_r <= sum_c[PW-1];
      ST_DIV: if (div_done) res_y_r <= sat_c;
      default: ;
    endcase
  end

  pli_div #(.NW(PW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_c),
    .divisor  (DW'(a_r) + DW'(b_r)),
    .done     (div_done),
    .quotient (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_y_r   <= FIELD_W'(res_y_r);
      out_oor_r <= res_oor_r;
      out_hit_r <= res_hit_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.interp_y     = out_y_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_ch.exact_hit    = out_hit_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_oor_r && out_hit_r))
    else $error("out_of_range and exact_hit together");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_y_r == '0))
    else $error("out of range result not zero");

  a_interval_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (a_r > 0 && b_r > 0))
    else $error("empty interval reached the multiplier");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qry_acc |=> !in_ch.ready)
    else $error("input taken while a query is in flight");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");
endmodule
